@@ rtl/hsv_to_rgb_converter_macros.svh @@
// Assertion macros used by the converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication.
`define HSV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

@@ rtl/hsv2rgb_pkg.sv @@
`default_nettype none

package hsv2rgb_pkg;

    localparam int NUM_STAGES = 7;

    localparam int HUE_W  = 16;
    localparam int PCT_W  = 7;
    localparam int CHAN_W = 8;
    localparam int HMOD_W = 9;
    localparam int OFS_W  = 6;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;

    localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
    localparam logic [HMOD_W-1:0] DEG_SECTOR = 9'd60;
    localparam logic [HUE_W-1:0]  DEG_FULL   = 16'd360;

    // floor(x/360) = (x*RECIP_360) >> SHIFT_360, exact for x < 2^16
    localparam logic [15:0] RECIP_360 = 16'd46604;
    localparam int          SHIFT_360 = 24;
    // floor(x/100) exact for x < 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          SHIFT_100 = 19;
    // floor(x/60) exact for x < 23831
    localparam logic [14:0] RECIP_60  = 15'd17477;
    localparam int          SHIFT_60  = 20;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_pipe_ctl;

endpackage

`default_nettype wire

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB converter. Each input beat carries a hue in degrees (any 16-bit
// value, wrapped modulo 360), a saturation and a value in percent (above 100
// treated as 100); each output beat carries 8-bit red, green and blue. The
// block takes one beat per clock when not stalled and runs it through a
// seven-stage pipeline of constant-reciprocal multiplies (hue wrap, peak
// scale, floor scale, ramp) and a final sector select. Every stage holds its
// beat under back-pressure and bubbles are squeezed out, so input stays ready
// while any stage is free.
`default_nettype none

`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // hue[15:0], saturation[22:16], brightness[29:23], zero pad[31:30]
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_valid, n_valid;
    logic [NUM_STAGES-1:0] w_ready;
    logic [NUM_STAGES-1:0] w_taken;
    t_pipe_ctl             w_ctl;
    logic [CHAN_W-1:0]     w_red, w_green, w_blue;

    always_comb begin
        w_ready[LAST] = !r_valid[LAST] || i_m_axis_tready;
        w_taken[LAST] = r_valid[LAST] && i_m_axis_tready;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_taken[k] = r_valid[k] && w_ready[k+1];
            w_ready[k] = !r_valid[k] || w_ready[k+1];
        end
        w_ctl.load[0] = i_s_axis_tvalid && w_ready[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            w_ctl.load[k] = r_valid[k-1] && w_ready[k];
        end
        n_valid = w_ctl.load | (r_valid & ~w_taken);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    hsv2rgb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_hue        (i_s_axis_tdata[HUE_W-1:0]),
        .i_saturation (i_s_axis_tdata[HUE_W +: PCT_W]),
        .i_brightness (i_s_axis_tdata[HUE_W+PCT_W +: PCT_W]),
        .o_red        (w_red),
        .o_green      (w_green),
        .o_blue       (w_blue)
    );

    assign o_s_axis_tready = w_ready[0];
    assign o_m_axis_tvalid = r_valid[LAST];
    assign o_m_axis_tdata  = {w_blue, w_green, w_red};

    `HSV_ASSERT_NEXT(a_accept_fills_first, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_valid[0])
    `HSV_ASSERT_NOW(a_full_stall_blocks_input, i_clk, i_rst_n, (&r_valid) && !i_m_axis_tready, !o_s_axis_tready)
    `HSV_ASSERT_NOW(a_last_load_has_source, i_clk, i_rst_n, w_ctl.load[LAST], r_valid[LAST-1])
    `HSV_ASSERT_NOW(a_bubble_means_ready, i_clk, i_rst_n, !(&r_valid), o_s_axis_tready)

endmodule

`default_nettype wire

@@ rtl/hsv2rgb_datapath.sv @@
`default_nettype none

module hsv2rgb_datapath
    import hsv2rgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_pipe_ctl         i_ctl,
    input  wire logic [HUE_W-1:0]  i_hue,
    input  wire logic [PCT_W-1:0]  i_saturation,
    input  wire logic [PCT_W-1:0]  i_brightness,
    output logic      [CHAN_W-1:0] o_red,
    output logic      [CHAN_W-1:0] o_green,
    output logic      [CHAN_W-1:0] o_blue
);

    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    // stage 0
    logic [PCT_W-1:0]  n_sat_c, n_bri_c;
    logic [31:0]       n_hq_prod;
    logic [HUE_W-1:0]  r0_hue;
    logic [7:0]        r0_hq;
    logic [14:0]       r0_vx;
    logic [PCT_W-1:0]  r0_sinv;
    // stage 1
    logic [HUE_W-1:0]  n_hsub;
    logic [27:0]       n_top_prod;
    logic [HMOD_W-1:0] r1_hmod;
    logic [CHAN_W-1:0] r1_top;
    logic [PCT_W-1:0]  r1_sinv;
    // stage 2
    t_sector           n_sector;
    logic [HMOD_W-1:0] n_base;
    logic [HMOD_W-1:0] n_ofs_full;
    logic [14:0]       r2_prod;
    logic [CHAN_W-1:0] r2_top;
    t_sector           r2_sector;
    logic [OFS_W-1:0]  r2_offset;
    // stage 3
    logic [27:0]       n_bot_prod;
    logic [CHAN_W-1:0] r3_bot, r3_top;
    t_sector           r3_sector;
    logic [OFS_W-1:0]  r3_offset;
    // stage 4
    logic [CHAN_W-1:0] n_span;
    logic [13:0]       r4_rp;
    logic [CHAN_W-1:0] r4_bot, r4_top;
    t_sector           r4_sector;
    // stage 5
    logic [28:0]       n_ramp_prod;
    logic [CHAN_W-1:0] r5_ramp, r5_bot, r5_top;
    t_sector           r5_sector;
    // stage 6
    logic [CHAN_W-1:0] n_rise, n_fall;
    logic [CHAN_W-1:0] n_red, n_green, n_blue;
    logic [CHAN_W-1:0] r6_red, r6_green, r6_blue;

    always_comb begin
        n_sat_c   = (i_saturation > PCT_FULL) ? PCT_FULL : i_saturation;
        n_bri_c   = (i_brightness > PCT_FULL) ? PCT_FULL : i_brightness;
        n_hq_prod = 32'(i_hue) * 32'(RECIP_360);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            r0_hue  <= i_hue;
            r0_hq   <= n_hq_prod[SHIFT_360 +: 8];
            r0_vx   <= {n_bri_c, 8'd0} - 15'(n_bri_c);
            r0_sinv <= PCT_FULL - n_sat_c;
        end
    end

    always_comb begin
        n_hsub     = r0_hue - 16'(r0_hq) * DEG_FULL;
        n_top_prod = 28'(r0_vx) * 28'(RECIP_100);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r1_hmod <= n_hsub[HMOD_W-1:0];
            r1_top  <= n_top_prod[SHIFT_100 +: CHAN_W];
            r1_sinv <= r0_sinv;
        end
    end

    always_comb begin
        if (r1_hmod >= 9'(5 * DEG_SECTOR)) begin
            n_sector = SEC_MAGENTA;
            n_base   = 9'(5 * DEG_SECTOR);
        end else if (r1_hmod >= 9'(4 * DEG_SECTOR)) begin
            n_sector = SEC_BLUE;
            n_base   = 9'(4 * DEG_SECTOR);
        end else if (r1_hmod >= 9'(3 * DEG_SECTOR)) begin
            n_sector = SEC_CYAN;
            n_base   = 9'(3 * DEG_SECTOR);
        end else if (r1_hmod >= 9'(2 * DEG_SECTOR)) begin
            n_sector = SEC_GREEN;
            n_base   = 9'(2 * DEG_SECTOR);
        end else if (r1_hmod >= DEG_SECTOR) begin
            n_sector = SEC_YELLOW;
            n_base   = DEG_SECTOR;
        end else begin
            n_sector = SEC_RED;
            n_base   = '0;
        end
        n_ofs_full = r1_hmod - n_base;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r2_prod   <= 15'(r1_top) * 15'(r1_sinv);
            r2_top    <= r1_top;
            r2_sector <= n_sector;
            r2_offset <= n_ofs_full[OFS_W-1:0];
        end
    end

    assign n_bot_prod = 28'(r2_prod) * 28'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r3_bot    <= n_bot_prod[SHIFT_100 +: CHAN_W];
            r3_top    <= r2_top;
            r3_sector <= r2_sector;
            r3_offset <= r2_offset;
        end
    end

    assign n_span = r3_top - r3_bot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[4]) begin
            r4_rp     <= 14'(n_span) * 14'(r3_offset);
            r4_bot    <= r3_bot;
            r4_top    <= r3_top;
            r4_sector <= r3_sector;
        end
    end

    assign n_ramp_prod = 29'(r4_rp) * 29'(RECIP_60);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[5]) begin
            r5_ramp   <= n_ramp_prod[SHIFT_60 +: CHAN_W];
            r5_bot    <= r4_bot;
            r5_top    <= r4_top;
            r5_sector <= r4_sector;
        end
    end

    always_comb begin
        n_rise = r5_bot + r5_ramp;
        n_fall = r5_top - r5_ramp;
        unique case (r5_sector)
            SEC_RED: begin
                n_red = r5_top;  n_green = n_rise; n_blue = r5_bot;
            end
            SEC_YELLOW: begin
                n_red = n_fall;  n_green = r5_top; n_blue = r5_bot;
            end
            SEC_GREEN: begin
                n_red = r5_bot;  n_green = r5_top; n_blue = n_rise;
            end
            SEC_CYAN: begin
                n_red = r5_bot;  n_green = n_fall; n_blue = r5_top;
            end
            SEC_BLUE: begin
                n_red = n_rise;  n_green = r5_bot; n_blue = r5_top;
            end
            default: begin
                n_red = r5_top;  n_green = r5_bot; n_blue = n_fall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[6]) begin
            r6_red   <= n_red;
            r6_green <= n_green;
            r6_blue  <= n_blue;
        end
    end

    assign o_red   = r6_red;
    assign o_green = r6_green;
    assign o_blue  = r6_blue;

endmodule

`default_nettype wire

@@ tb/hsv_to_rgb_converter_checker.sv @@
`default_nettype none

module hsv_to_rgb_converter_checker
    import hsv2rgb_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_tvalid,
    input  wire logic                   i_in_tready,
    // hue[15:0], saturation[22:16], brightness[29:23], zero pad[31:30]
    input  wire logic [IN_TDATA_W-1:0]  i_in_tdata,
    input  wire logic                   i_out_tvalid,
    input  wire logic                   i_out_tready,
    // red[7:0], green[15:8], blue[23:16]
    input  wire logic [OUT_TDATA_W-1:0] i_out_tdata,
    output int unsigned                 o_mismatches,
    output int unsigned                 o_pending
);

    localparam int unsigned CHAN_MAX = 255;

    typedef struct packed {
        logic [1:0]        pad;
        logic [PCT_W-1:0]  brightness;
        logic [PCT_W-1:0]  saturation;
        logic [HUE_W-1:0]  hue;
    } hsv_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    // color wheel order: red, yellow, green, cyan, blue, magenta
    typedef enum int unsigned {
        SEC_RED_YELLOW,
        SEC_YELLOW_GREEN,
        SEC_GREEN_CYAN,
        SEC_CYAN_BLUE,
        SEC_BLUE_MAGENTA,
        SEC_MAGENTA_RED
    } hue_sector_e;

    rgb_t        expected_colors[$];
    int unsigned mismatch_cnt = 0;
    int unsigned pending_cnt  = 0;

    assign o_mismatches = mismatch_cnt;
    assign o_pending    = pending_cnt;

    function automatic rgb_t rgb_from_hsv(hsv_t px);
        int unsigned h, sat, val, peak, base, offset, ramp, rise, fall, r, g, b;
        hue_sector_e sector;
        rgb_t        c;
        h      = px.hue % DEG_FULL;
        sat    = (px.saturation > PCT_FULL) ? PCT_FULL : px.saturation;
        val    = (px.brightness > PCT_FULL) ? PCT_FULL : px.brightness;
        peak   = val * CHAN_MAX / PCT_FULL;
        base   = peak * (PCT_FULL - sat) / PCT_FULL;
        sector = hue_sector_e'(h / DEG_SECTOR);
        offset = h % DEG_SECTOR;
        ramp   = (peak - base) * offset / DEG_SECTOR;
        rise   = base + ramp;
        fall   = peak - ramp;
        case (sector)
            SEC_RED_YELLOW: begin
                r = peak; g = rise; b = base;
            end
            SEC_YELLOW_GREEN: begin
                r = fall; g = peak; b = base;
            end
            SEC_GREEN_CYAN: begin
                r = base; g = peak; b = rise;
            end
            SEC_CYAN_BLUE: begin
                r = base; g = fall; b = peak;
            end
            SEC_BLUE_MAGENTA: begin
                r = rise; g = base; b = peak;
            end
            default: begin
                r = peak; g = base; b = fall;
            end
        endcase
        c.red   = CHAN_W'(r);
        c.green = CHAN_W'(g);
        c.blue  = CHAN_W'(b);
        return c;
    endfunction

    function automatic int unsigned channel_differs(string name, logic [CHAN_W-1:0] want,
                                                    logic [CHAN_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        rgb_t want, got;
        if (i_rst_n) begin
            if (i_out_tvalid && i_out_tready) begin
                got = rgb_t'(i_out_tdata);
                if (expected_colors.size() == 0) begin
                    $display("%0t: unexpected output beat, expected none, got r=%0d g=%0d b=%0d",
                             $time, got.red, got.green, got.blue);
                    mismatch_cnt = mismatch_cnt + 1;
                end else begin
                    want = expected_colors.pop_front();
                    mismatch_cnt = mismatch_cnt + channel_differs("red", want.red, got.red)
                                 + channel_differs("green", want.green, got.green)
                                 + channel_differs("blue", want.blue, got.blue);
                end
            end
            if (i_in_tvalid && i_in_tready)
                expected_colors.push_back(rgb_from_hsv(hsv_t'(i_in_tdata)));
        end
        pending_cnt <= expected_colors.size();
    end

endmodule

`default_nettype wire

@@ tb/hsv_to_rgb_converter_tb.sv @@
`default_nettype none

module hsv_to_rgb_converter_tb;
    import hsv2rgb_pkg::*;

    localparam int RANDOM_BEATS = 1950;
    localparam int NUM_PHASES   = 5;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int NUM_CORNERS  = 24;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    int unsigned mismatch_count;
    int unsigned pending_count;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;

    // hue, saturation, brightness
    int unsigned corner_hsv [NUM_CORNERS][3] = '{
        '{0, 100, 100},   '{59, 100, 100},  '{60, 100, 100},  '{119, 100, 100},
        '{120, 100, 100}, '{179, 100, 100}, '{180, 100, 100}, '{239, 100, 100},
        '{240, 100, 100}, '{299, 100, 100}, '{300, 100, 100}, '{359, 100, 100},
        '{360, 100, 100}, '{719, 50, 50},   '{65535, 100, 100}, '{30, 0, 100},
        '{200, 0, 73},    '{90, 100, 0},    '{150, 127, 127}, '{270, 101, 101},
        '{45, 127, 0},    '{330, 0, 0},     '{65000, 37, 88}, '{16383, 64, 64}
    };
    int unsigned phase_idle_pct  [NUM_PHASES] = '{0, 46, 0, 17, 0};
    int unsigned phase_stall_pct [NUM_PHASES] = '{0, 0, 46, 17, 0};

    hsv_to_rgb_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    hsv_to_rgb_converter_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (i_s_axis_tvalid),
        .i_in_tready  (o_s_axis_tready),
        .i_in_tdata   (i_s_axis_tdata),
        .i_out_tvalid (o_m_axis_tvalid),
        .i_out_tready (i_m_axis_tready),
        .i_out_tdata  (o_m_axis_tdata),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    function automatic logic [IN_TDATA_W-1:0] pack_hsv(logic [HUE_W-1:0] hue,
                                                       logic [PCT_W-1:0] sat,
                                                       logic [PCT_W-1:0] bri);
        return {2'b00, bri, sat, hue};
    endfunction

    // bias toward in-range percentages and the first two hue turns
    function automatic logic [IN_TDATA_W-1:0] random_hsv();
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat, bri;
        hue = ($urandom_range(0, 3) == 0) ? HUE_W'($urandom_range(0, 719)) : HUE_W'($urandom);
        sat = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(101, 127))
                                          : PCT_W'($urandom_range(0, 100));
        bri = ($urandom_range(0, 7) == 0) ? PCT_W'($urandom_range(101, 127))
                                          : PCT_W'($urandom_range(0, 100));
        return pack_hsv(hue, sat, bri);
    endfunction

    task automatic send_hsv(logic [IN_TDATA_W-1:0] beat);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NUM_CORNERS; k++)
            send_hsv(pack_hsv(HUE_W'(corner_hsv[k][0]), PCT_W'(corner_hsv[k][1]),
                              PCT_W'(corner_hsv[k][2])));

        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  <= phase_idle_pct[p];
            recv_stall_pct <= phase_stall_pct[p];
            for (int n = 0; n < RANDOM_BEATS / NUM_PHASES; n++)
                send_hsv(random_hsv());
        end
        i_s_axis_tvalid <= 1'b0;
        recv_stall_pct  <= 0;

        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
